/* sv/dccd_pkg.sv */
// ----------------------------------------------------------------------------
// Chunk dispatcher package
// Shared types and constants for the degree-capped chunk dispatcher.
// ----------------------------------------------------------------------------
package dccd_pkg;

   localparam logic [1:0] CMD_NODE     = 2'd0;
   localparam logic [1:0] CMD_NEIGHBOR = 2'd1;
   localparam logic [1:0] CMD_FINISH   = 2'd2;

   localparam logic [1:0] KIND_HUB     = 2'd0;
   localparam logic [1:0] KIND_CHUNK   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] CSR_PE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_CHUNK_CAP = 2'd1;
   localparam logic [1:0] CSR_HUB_COUNT = 2'd2;

   localparam logic [47:0] SAT48 = {48{1'b1}};
   localparam logic [55:0] SAT56 = {56{1'b1}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_req;     // hold the degrees of the accepted word
      logic use_held;     // accumulate from the held degrees
      logic node_add;     // accumulate the current node into the open chunk
      logic neigh_add;    // add neighbor cost
      logic close_calc;   // register the chunk work figures
      logic close_load;   // read the PE store entry of the closing chunk
      logic close_commit; // write the PE store and present the chunk word
      logic hub_emit;     // present a hub word
      logic scan_start;   // begin a pass over the PE entries (busiest PE scan or clear)
      logic scan_step;    // compare one PE entry
      logic sum_emit;     // present the summary word
      logic clear_step;   // clear one PE entry
      logic clear_regs;   // return chunk state to reset values
      logic last;         // mark the word being presented as the last one
   } dccd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_hub;
      logic over_cap;
      logic chunk_open;
      logic in_nonhub;
      logic scan_done;
      logic clear_done;
   } dccd_stat_type;

endpackage

/* sv/degree_capped_chunk_dispatcher.sv */
// ----------------------------------------------------------------------------
// Degree-capped chunk dispatcher
// Packs graph nodes into degree-capped chunks and assigns PEs round-robin.
// ----------------------------------------------------------------------------
// After reset the block clears its PE work store in a pass over every entry
// and holds req_stall until the pass is done. A node or neighbor word that
// adds to the open chunk, a hub word with no chunk open and a stray neighbor
// are handled in S_IDLE, and a word can follow in the next cycle unless the
// output is stalled. A node that closes a chunk passes through S_CALC,
// S_LOAD, S_COMMIT and S_AFTER for the read-modify-write of the PE work
// store and waits while the output is stalled. A finish word closes a chunk
// that is still open, then passes once over the active PE entries to find the
// busiest PE, presents the summary and clears the whole store in a second pass.
module degree_capped_chunk_dispatcher
   import dccd_pkg::*;
#(
   parameter int MAX_PE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [23:0] req_high_degree,
   input  logic [23:0] req_other_degree,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_pe_index,
   output logic [31:0] rsp_first_node,
   output logic [31:0] rsp_end_node,
   output logic [32:0] rsp_edge_total,
   output logic [47:0] rsp_search_ops,
   output logic [47:0] rsp_pair_ops,
   output logic [31:0] rsp_nonhub_edges,
   output logic [55:0] rsp_chunk_work,
   output logic [55:0] rsp_pe_work_total,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [6:0]  pe_num_ff;
   logic [31:0] chunk_cap_ff, hub_count_ff;
   dccd_cmd_type  cmd;
   dccd_stat_type stat;
   logic out_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_num_ff    <= 7'd1;
         chunk_cap_ff <= 32'd1024;
         hub_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PE_COUNT:  pe_num_ff    <= csr_data[6:0];
            CSR_CHUNK_CAP: chunk_cap_ff <= csr_data;
            CSR_HUB_COUNT: hub_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dccd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_command,
      .out_busy, .stat, .cmd
   );

   dccd_dp #(.MAX_PE(MAX_PE)) u_dp (
      .clock, .reset, .req_high_degree, .req_other_degree,
      .pe_num(pe_num_ff), .chunk_cap(chunk_cap_ff), .hub_count(hub_count_ff),
      .cmd, .stat, .rsp_stall, .out_busy, .rsp_valid, .rsp_kind, .rsp_pe_index,
      .rsp_first_node, .rsp_end_node, .rsp_edge_total, .rsp_search_ops,
      .rsp_pair_ops, .rsp_nonhub_edges, .rsp_chunk_work, .rsp_pe_work_total,
      .rsp_last
   );

endmodule

/* sv/dccd_ctrl.sv */
// ----------------------------------------------------------------------------
// Chunk dispatcher controller
// Sequences node, neighbor and finish words through the datapath.
// ----------------------------------------------------------------------------
module dccd_ctrl
   import dccd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  logic          out_busy,
   input  dccd_stat_type stat,
   output dccd_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CALC, S_LOAD, S_COMMIT, S_AFTER, S_SCAN, S_SCAN2, S_SUM, S_CLEAR, S_WAIT
   } state_type;

   typedef enum logic [1:0] {
      A_NODE_HUB, A_NODE_ADD, A_FINISH
   } after_type;

   state_type state_ff, state_in;
   after_type after_ff, after_in;

   assign req_stall = (state_ff != S_IDLE) || out_busy;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.take_req = 1'b1;
               case (req_command)
                  CMD_NODE: begin
                     if (stat.chunk_open && (stat.is_hub || stat.over_cap)) begin
                        after_in = stat.is_hub ? A_NODE_HUB : A_NODE_ADD;
                        state_in = S_CALC;
                     end else if (stat.is_hub) begin
                        cmd.hub_emit = 1'b1;
                        cmd.last = 1'b1;
                     end else begin
                        cmd.node_add = 1'b1;
                     end
                  end
                  CMD_NEIGHBOR: cmd.neigh_add = stat.in_nonhub && stat.chunk_open;
                  CMD_FINISH: begin
                     after_in = A_FINISH;
                     state_in = stat.chunk_open ? S_CALC : S_SCAN;
                     cmd.scan_start = !stat.chunk_open;
                  end
                  default: ;
               endcase
            end
         end
         S_CALC: begin
            cmd.close_calc = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.close_load = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!out_busy) begin
               cmd.close_commit = 1'b1;
               // A node that only closes the chunk gives no further word.
               cmd.last = (after_ff == A_NODE_ADD);
               state_in = S_AFTER;
            end
         end
         S_AFTER: begin
            case (after_ff)
               A_NODE_HUB: begin
                  if (!out_busy) begin
                     cmd.hub_emit = 1'b1;
                     cmd.last = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               A_NODE_ADD: begin
                  cmd.node_add = 1'b1;
                  cmd.use_held = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_SCAN2;
         end
         S_SCAN2: state_in = S_SUM;
         S_SUM: begin
            if (!out_busy) begin
               cmd.sum_emit = 1'b1;
               cmd.last = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               cmd.clear_regs = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Reset starts with a clearing pass over the whole PE store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         after_ff <= A_NODE_ADD;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && !out_busy) |=> state_ff == S_AFTER)
      else $error("chunk commit did not advance");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("word accepted while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && !out_busy) |=> state_ff == S_CLEAR)
      else $error("summary did not start clear pass");

endmodule

/* sv/dccd_dp.sv */
// ----------------------------------------------------------------------------
// Chunk dispatcher datapath
// Chunk accumulators, PE work store, round-robin pointers and output register.
// ----------------------------------------------------------------------------
module dccd_dp
   import dccd_pkg::*;
#(
   parameter int MAX_PE = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [23:0]   req_high_degree,
   input  logic [23:0]   req_other_degree,
   input  logic [6:0]    pe_num,
   input  logic [31:0]   chunk_cap,
   input  logic [31:0]   hub_count,
   input  dccd_cmd_type  cmd,
   output dccd_stat_type stat,
   input  logic          rsp_stall,
   output logic          out_busy,
   output logic          rsp_valid,
   output logic [1:0]    rsp_kind,
   output logic [5:0]    rsp_pe_index,
   output logic [31:0]   rsp_first_node,
   output logic [31:0]   rsp_end_node,
   output logic [32:0]   rsp_edge_total,
   output logic [47:0]   rsp_search_ops,
   output logic [47:0]   rsp_pair_ops,
   output logic [31:0]   rsp_nonhub_edges,
   output logic [55:0]   rsp_chunk_work,
   output logic [55:0]   rsp_pe_work_total,
   output logic          rsp_last
);

   localparam int PW = (MAX_PE > 1) ? $clog2(MAX_PE) : 1;
   localparam int CW = $clog2(MAX_PE + 1);

   logic [CW-1:0] npe;
   always_comb begin
      if (pe_num == 7'd0) npe = CW'(1);
      else if (32'(pe_num) > 32'(MAX_PE)) npe = CW'(MAX_PE);
      else npe = CW'(pe_num);
   end

   logic [31:0] node_ff, start_ff;
   logic [CW-1:0] hub_ptr_ff, chunk_ptr_ff, close_pe_ff;
   logic open_ff, nonhub_ff;
   logic [32:0] high_ff, other_ff;
   logic [47:0] search_ff, pair_ff, run_search_ff, run_pair_ff;
   logic [47:0] tri_ff;
   logic        tri_pending_ff;
   logic [55:0] work_ff, store_rd_ff, best_work_ff;
   logic [55:0] store_mem [MAX_PE];
   logic [CW-1:0] scan_ff;
   logic [PW-1:0] best_ff;
   logic [55:0] scan_rd_ff;
   logic [PW-1:0] scan_idx_ff;
   logic        scan_vld_ff;

   // A node that first closes a chunk is added later from the held degrees.
   logic [23:0] held_high_ff, held_other_ff;
   logic [23:0] deg_h, deg_o;
   assign deg_h = cmd.use_held ? held_high_ff : req_high_degree;
   assign deg_o = cmd.use_held ? held_other_ff : req_other_degree;

   // Pair term h*(h-1)/2 is registered and folded in on the next cycle.
   logic [23:0] hm1;
   logic [47:0] prod;
   assign hm1  = deg_h - 24'd1;
   assign prod = deg_h * hm1;

   logic [48:0] pair_add;
   assign pair_add = {1'b0, pair_ff} + {1'b0, tri_ff};

   assign stat.is_hub     = node_ff < hub_count;
   assign stat.over_cap   = (high_ff + 33'(req_high_degree) > {1'b0, chunk_cap})
                         || (other_ff + 33'(req_other_degree) > {1'b0, chunk_cap});
   assign stat.chunk_open = open_ff;
   assign stat.in_nonhub  = nonhub_ff;
   assign stat.scan_done  = (scan_ff + CW'(1) >= npe);
   assign stat.clear_done = (scan_ff == CW'(MAX_PE - 1));

   function automatic logic [CW-1:0] ptr_use(input logic [CW-1:0] p, input logic [CW-1:0] n);
      ptr_use = (p < n) ? p : '0;
   endfunction
   function automatic logic [CW-1:0] ptr_next(input logic [CW-1:0] p, input logic [CW-1:0] n);
      logic [CW:0] q;
      q = {1'b0, ptr_use(p, n)} + 1'b1;
      ptr_next = (q < {1'b0, n}) ? q[CW-1:0] : '0;
   endfunction

   logic [32:0] edge_w;
   logic [57:0] w_full;
   logic [55:0] w_sat;
   assign edge_w = high_ff + other_ff;
   assign w_full = {24'd0, edge_w, 1'b0} + {10'd0, search_ff}
                 + {9'd0, pair_add[47:0], 1'b0} + {24'd0, other_ff, 1'b0};
   assign w_sat  = (w_full > {2'b0, SAT56}) ? SAT56 : w_full[55:0];

   logic [56:0] st_sum;
   assign st_sum = {1'b0, store_rd_ff} + {1'b0, work_ff};

   assign out_busy = rsp_valid && rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         held_high_ff <= req_high_degree;
         held_other_ff <= req_other_degree;
      end
      if (cmd.close_load) store_rd_ff <= store_mem[close_pe_ff[PW-1:0]];
      if (cmd.close_commit)
         store_mem[close_pe_ff[PW-1:0]] <= st_sum[56] ? SAT56 : st_sum[55:0];
      if (cmd.clear_step) store_mem[scan_ff[PW-1:0]] <= '0;
      // The scan reads one entry a cycle and compares it on the next.
      if (cmd.scan_step) begin
         scan_rd_ff <= store_mem[scan_ff[PW-1:0]];
         scan_idx_ff <= scan_ff[PW-1:0];
      end
      if (scan_vld_ff && scan_rd_ff > best_work_ff) begin
         best_work_ff <= scan_rd_ff;
         best_ff <= scan_idx_ff;
      end
      if (cmd.scan_start && !cmd.sum_emit) begin
         best_work_ff <= '0;
         best_ff <= '0;
      end
      if (cmd.close_calc) begin
         work_ff <= w_sat;
         close_pe_ff <= ptr_use(chunk_ptr_ff, npe);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0; start_ff <= '0; hub_ptr_ff <= '0; chunk_ptr_ff <= '0;
         open_ff <= 1'b0; nonhub_ff <= 1'b0; high_ff <= '0; other_ff <= '0;
         search_ff <= '0; pair_ff <= '0; run_search_ff <= '0; run_pair_ff <= '0;
         tri_ff <= '0; tri_pending_ff <= 1'b0; scan_ff <= '0; rsp_valid <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_step;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         if (tri_pending_ff) begin
            pair_ff <= pair_add[48] ? SAT48 : pair_add[47:0];
            tri_ff <= '0;
            tri_pending_ff <= 1'b0;
         end
         if (cmd.node_add) begin
            if (!open_ff) start_ff <= node_ff;
            open_ff <= 1'b1;
            high_ff <= high_ff + 33'(deg_h);
            other_ff <= other_ff + 33'(deg_o);
            tri_ff <= {1'b0, prod[47:1]};
            tri_pending_ff <= 1'b1;
            nonhub_ff <= 1'b1;
            node_ff <= node_ff + 32'd1;
         end
         if (cmd.neigh_add) begin
            search_ff <= ({1'b0, search_ff} + 49'(req_high_degree) + 49'(req_other_degree)
                          > {1'b0, SAT48}) ? SAT48
                       : search_ff + 48'(req_high_degree) + 48'(req_other_degree);
         end
         if (cmd.close_commit) begin
            chunk_ptr_ff <= ptr_next(chunk_ptr_ff, npe);
            run_search_ff <= ({1'b0, run_search_ff} + {1'b0, search_ff} > {1'b0, SAT48})
                           ? SAT48 : run_search_ff + search_ff;
            run_pair_ff <= ({1'b0, run_pair_ff} + {1'b0, pair_ff} > {1'b0, SAT48})
                         ? SAT48 : run_pair_ff + pair_ff;
            rsp_valid <= 1'b1;
            rsp_kind <= KIND_CHUNK;
            rsp_pe_index <= 6'(close_pe_ff);
            rsp_first_node <= start_ff;
            rsp_end_node <= node_ff;
            rsp_edge_total <= edge_w;
            rsp_search_ops <= search_ff;
            rsp_pair_ops <= pair_ff;
            rsp_nonhub_edges <= other_ff[31:0];
            rsp_chunk_work <= work_ff;
            rsp_pe_work_total <= st_sum[56] ? SAT56 : st_sum[55:0];
            rsp_last <= cmd.last;
            open_ff <= 1'b0;
            high_ff <= '0; other_ff <= '0; search_ff <= '0; pair_ff <= '0;
         end
         if (cmd.hub_emit) begin
            hub_ptr_ff <= ptr_next(hub_ptr_ff, npe);
            rsp_valid <= 1'b1;
            rsp_kind <= KIND_HUB;
            rsp_pe_index <= 6'(ptr_use(hub_ptr_ff, npe));
            rsp_first_node <= node_ff;
            rsp_end_node <= node_ff + 32'd1;
            rsp_edge_total <= '0; rsp_search_ops <= '0; rsp_pair_ops <= '0;
            rsp_nonhub_edges <= '0; rsp_chunk_work <= '0; rsp_pe_work_total <= '0;
            rsp_last <= 1'b1;
            nonhub_ff <= 1'b0;
            node_ff <= node_ff + 32'd1;
         end
         if (cmd.scan_start) scan_ff <= '0;
         else if (cmd.scan_step || cmd.clear_step) scan_ff <= scan_ff + CW'(1);
         if (cmd.sum_emit) begin
            rsp_valid <= 1'b1;
            rsp_kind <= KIND_SUMMARY;
            rsp_pe_index <= 6'(best_ff);
            rsp_first_node <= '0; rsp_end_node <= '0; rsp_edge_total <= '0;
            rsp_search_ops <= run_search_ff;
            rsp_pair_ops <= run_pair_ff;
            rsp_nonhub_edges <= '0; rsp_chunk_work <= '0;
            rsp_pe_work_total <= best_work_ff;
            rsp_last <= 1'b1;
         end
         if (cmd.clear_regs) begin
            node_ff <= '0; start_ff <= '0; hub_ptr_ff <= '0; chunk_ptr_ff <= '0;
            open_ff <= 1'b0; nonhub_ff <= 1'b0; high_ff <= '0; other_ff <= '0;
            search_ff <= '0; pair_ff <= '0; run_search_ff <= '0; run_pair_ff <= '0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.close_commit |-> open_ff)
      else $error("closing a chunk that is not open");
   assert property (@(posedge clock) disable iff (reset)
      cmd.close_commit |=> !open_ff && high_ff == '0)
      else $error("chunk sums not cleared after close");
   assert property (@(posedge clock) disable iff (reset)
      cmd.sum_emit |-> !open_ff)
      else $error("summary with chunk still open");

endmodule
